// ===== design/bmr_pkg.sv =====
// Shared types and constants for the byte grid rotator.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bmr_pkg;

  localparam int FUNC_W = 2;
  localparam int POS_W  = 2;
  localparam int AMT_W  = 2;
  localparam int BYTE_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_ROT_ROW = 2'd2,
    FUNC_ROT_COL = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_ctrl_t;

endpackage

`default_nettype wire

// ===== design/bmr_chan_if.sv =====
// Valid/ready channel interfaces for the byte grid rotator.
// Depends on bmr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bmr_in_if;
  logic                        valid;
  logic                        ready;
  logic [bmr_pkg::FUNC_W-1:0]  func;
  logic [bmr_pkg::POS_W-1:0]   pos_col;
  logic [bmr_pkg::POS_W-1:0]   pos_row;
  logic [bmr_pkg::AMT_W-1:0]   amount;
  logic                        toward;
  logic [bmr_pkg::BYTE_W-1:0]  write_value;

  modport source (output valid, func, pos_col, pos_row, amount, toward, write_value,
                  input ready);
  modport sink (input valid, func, pos_col, pos_row, amount, toward, write_value,
                output ready);
endinterface

interface bmr_out_if;
  logic                        valid;
  logic                        ready;
  logic [bmr_pkg::BYTE_W-1:0]  read_value;

  modport source (output valid, read_value, input ready);
  modport sink (input valid, read_value, output ready);
endinterface

`default_nettype wire

// ===== design/bmr_ctrl.sv =====
// Sequencing controller for the byte grid rotator: captures a transaction,
// runs it once the result register is free, and owns the result valid flag.
// Depends on bmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bmr_pkg::dp_ctrl_t      ctrl
);

  bmr_pkg::ctrl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 res_free;

  assign res_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bmr_pkg::ST_EXEC;
        end
      end
      bmr_pkg::ST_EXEC: begin
        if (res_free) begin
          state_nxt = bmr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bmr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    ctrl.capture = 1'b0;
    ctrl.execute = 1'b0;
    case (state_r)
      bmr_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        ctrl.capture = in_valid;
      end
      bmr_pkg::ST_EXEC: begin
        ctrl.execute = res_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted transaction is always followed by the execute state.
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == bmr_pkg::ST_EXEC))
    else $error("accepted transaction did not enter execute");

  // Execution never overwrites a result that has not been taken.
  a_exec_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.execute |-> (!out_valid_r || out_ready))
    else $error("execute while result register is occupied");

  // A result appears only right after an execution.
  a_valid_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.execute))
    else $error("result valid without execution");

endmodule

`default_nettype wire

// ===== design/bmr_datapath.sv =====
// Datapath of the byte grid rotator: command register, grid of byte
// registers with row and column rotation multiplexers, and the result register.
// Depends on bmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmr_datapath #(
  parameter int GRID_WIDTH  = 4,
  parameter int GRID_HEIGHT = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bmr_pkg::dp_ctrl_t           ctrl,
  input  wire logic [bmr_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [bmr_pkg::POS_W-1:0]   in_pos_col,
  input  wire logic [bmr_pkg::POS_W-1:0]   in_pos_row,
  input  wire logic [bmr_pkg::AMT_W-1:0]   in_amount,
  input  wire logic                        in_toward,
  input  wire logic [bmr_pkg::BYTE_W-1:0]  in_write_value,
  output logic [bmr_pkg::BYTE_W-1:0]       out_read_value
);

  localparam int CW    = $clog2(GRID_WIDTH);
  localparam int RW    = $clog2(GRID_HEIGHT);
  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam logic [CW+1:0] COL_MASK = (CW+2)'(GRID_WIDTH - 1);
  localparam logic [RW+1:0] ROW_MASK = (RW+2)'(GRID_HEIGHT - 1);

  bmr_pkg::func_t                func_r;
  logic [bmr_pkg::POS_W-1:0]     col_r;
  logic [bmr_pkg::POS_W-1:0]     row_r;
  logic [bmr_pkg::AMT_W-1:0]     amt_r;
  logic                          toward_r;
  logic [bmr_pkg::BYTE_W-1:0]    wval_r;

  logic [bmr_pkg::BYTE_W-1:0]    grid_r   [CELLS];
  logic [bmr_pkg::BYTE_W-1:0]    grid_nxt [CELLS];
  logic [bmr_pkg::BYTE_W-1:0]    read_value_r, read_value_nxt;

  logic [CW-1:0]                 col_m, amt_row;
  logic [RW-1:0]                 row_m, amt_col;
  logic [AW-1:0]                 idx;

  logic [bmr_pkg::BYTE_W-1:0]    row_line [GRID_WIDTH];
  logic [bmr_pkg::BYTE_W-1:0]    row_rot  [GRID_WIDTH];
  logic [bmr_pkg::BYTE_W-1:0]    col_line [GRID_HEIGHT];
  logic [bmr_pkg::BYTE_W-1:0]    col_rot  [GRID_HEIGHT];

  // Indices and amounts are masked with the line length minus one.
  assign col_m   = CW'((CW+2)'(col_r) & COL_MASK);
  assign row_m   = RW'((RW+2)'(row_r) & ROW_MASK);
  assign amt_row = CW'((CW+2)'(amt_r) & COL_MASK);
  assign amt_col = RW'((RW+2)'(amt_r) & ROW_MASK);
  assign idx     = AW'(col_m) + AW'(row_m) * AW'(GRID_WIDTH);

  always_comb begin
    for (int c = 0; c < GRID_WIDTH; c++) begin
      row_line[c] = '0;
      for (int r = 0; r < GRID_HEIGHT; r++) begin
        if (row_m == RW'(r)) begin
          row_line[c] = grid_r[r * GRID_WIDTH + c];
        end
      end
    end
    for (int r = 0; r < GRID_HEIGHT; r++) begin
      col_line[r] = '0;
      for (int c = 0; c < GRID_WIDTH; c++) begin
        if (col_m == CW'(c)) begin
          col_line[r] = grid_r[r * GRID_WIDTH + c];
        end
      end
    end
  end

  // Left or up takes from i+t, right or down from i-t, both modulo the length.
  always_comb begin
    logic [CW:0] rs;
    for (int c = 0; c < GRID_WIDTH; c++) begin
      if (toward_r) begin
        rs = (CW+1)'(c) + (CW+1)'(GRID_WIDTH) - (CW+1)'(amt_row);
      end else begin
        rs = (CW+1)'(c) + (CW+1)'(amt_row);
      end
      if (rs >= (CW+1)'(GRID_WIDTH)) begin
        rs = rs - (CW+1)'(GRID_WIDTH);
      end
      row_rot[c] = row_line[rs[CW-1:0]];
    end
  end

  always_comb begin
    logic [RW:0] cs;
    for (int r = 0; r < GRID_HEIGHT; r++) begin
      if (toward_r) begin
        cs = (RW+1)'(r) + (RW+1)'(GRID_HEIGHT) - (RW+1)'(amt_col);
      end else begin
        cs = (RW+1)'(r) + (RW+1)'(amt_col);
      end
      if (cs >= (RW+1)'(GRID_HEIGHT)) begin
        cs = cs - (RW+1)'(GRID_HEIGHT);
      end
      col_rot[r] = col_line[cs[RW-1:0]];
    end
  end

  always_comb begin
    for (int k = 0; k < CELLS; k++) begin
      grid_nxt[k] = grid_r[k];
    end
    read_value_nxt = read_value_r;
    if (ctrl.execute) begin
      read_value_nxt = '0;
      for (int r = 0; r < GRID_HEIGHT; r++) begin
        for (int c = 0; c < GRID_WIDTH; c++) begin
          case (func_r)
            bmr_pkg::FUNC_WRITE: begin
              if (idx == AW'(r * GRID_WIDTH + c)) begin
                grid_nxt[r * GRID_WIDTH + c] = wval_r;
              end
            end
            bmr_pkg::FUNC_ROT_ROW: begin
              if (row_m == RW'(r)) begin
                grid_nxt[r * GRID_WIDTH + c] = row_rot[c];
              end
            end
            bmr_pkg::FUNC_ROT_COL: begin
              if (col_m == CW'(c)) begin
                grid_nxt[r * GRID_WIDTH + c] = col_rot[r];
              end
            end
            default: begin
              grid_nxt[r * GRID_WIDTH + c] = grid_r[r * GRID_WIDTH + c];
            end
          endcase
        end
      end
      if (func_r == bmr_pkg::FUNC_READ) begin
        read_value_nxt = grid_r[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      func_r   <= bmr_pkg::func_t'(in_func);
      col_r    <= in_pos_col;
      row_r    <= in_pos_row;
      amt_r    <= in_amount;
      toward_r <= in_toward;
      wval_r   <= in_write_value;
    end
    read_value_r <= read_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CELLS; k++) begin
        grid_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < CELLS; k++) begin
        grid_r[k] <= grid_nxt[k];
      end
    end
  end

  assign out_read_value = read_value_r;

  // Only a read transaction returns a nonzero byte.
  a_zero_unless_read: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.execute && func_r != bmr_pkg::FUNC_READ) |=> (read_value_r == '0))
    else $error("nonzero result for a transaction other than read");

endmodule

`default_nettype wire

// ===== design/byte_matrix_row_col_rotator_core.sv =====
// Byte grid rotator top level: GRID_WIDTH x GRID_HEIGHT byte registers with
// write, read, row rotation and column rotation. Depends on bmr_pkg,
// bmr_chan_if, bmr_ctrl and bmr_datapath.
`timescale 1ns / 1ps
`default_nettype none

// A transaction is accepted in the idle state, in which the command is
// registered, and then runs in the execute state, in which the whole row or
// column passes through the rotation multiplexers into the grid registers and
// the result register is loaded. The controller holds one transaction at a
// time, so it takes no new one until the last has executed; a result not yet
// taken holds the execute state until out_ch.ready frees the result register. Every
// transaction returns exactly one result; it is the addressed byte for a read
// and zero otherwise. Indices and rotation amounts are masked with the line
// length minus one, and the grid is all zero after reset.
module byte_matrix_row_col_rotator_core #(
  parameter int GRID_WIDTH  = 4,
  parameter int GRID_HEIGHT = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bmr_in_if.sink     in_ch,
  bmr_out_if.source  out_ch
);

  bmr_pkg::dp_ctrl_t ctrl;

  bmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctrl      (ctrl)
  );

  bmr_datapath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .in_func        (in_ch.func),
    .in_pos_col     (in_ch.pos_col),
    .in_pos_row     (in_ch.pos_row),
    .in_amount      (in_ch.amount),
    .in_toward      (in_ch.toward),
    .in_write_value (in_ch.write_value),
    .out_read_value (out_ch.read_value)
  );

endmodule

`default_nettype wire

// ===== verif/byte_matrix_row_col_rotator_core_tb.sv =====
// Self-checking testbench for byte_matrix_row_col_rotator_core: it drives random and
// directed grid operations and compares every read_value against a grid predictor.
// Depends on bmr_pkg, bmr_chan_if and the RTL of the core.
`timescale 1ns / 1ps

module byte_matrix_row_col_rotator_core_tb;

  localparam int GRID_WIDTH  = 4;
  localparam int GRID_HEIGHT = 4;
  localparam int GRID_CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int N_RANDOM    = 950;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    bmr_pkg::func_t                func;
    logic [bmr_pkg::POS_W-1:0]     col;
    logic [bmr_pkg::POS_W-1:0]     row;
    logic [bmr_pkg::AMT_W-1:0]     amt;
    logic                          toward;
    logic [bmr_pkg::BYTE_W-1:0]    wval;
    bit                            wait_drain;
  } grid_op_t;

  logic clk;
  logic rst_n;

  bmr_in_if  in_ch();
  bmr_out_if out_ch();

  byte_matrix_row_col_rotator_core #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  grid_op_t                      pending_ops[$];
  logic [bmr_pkg::BYTE_W-1:0]    expected_bytes[$];
  logic [bmr_pkg::BYTE_W-1:0]    grid_mem[GRID_CELLS];
  grid_op_t                      cur_op;
  int                            sent_cnt;
  int                            checked_cnt;
  int                            errors;
  int                            tx_gap;
  int                            rx_wait;
  int                            idle_cycles;
  bit                            tx_burst;
  bit                            rx_burst;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Updates the predicted grid for one operation and returns the byte it reads.
  function automatic logic [bmr_pkg::BYTE_W-1:0] apply_op(grid_op_t op);
    int                            c;
    int                            r;
    int                            t;
    int                            src;
    logic [bmr_pkg::BYTE_W-1:0]    line[GRID_CELLS];
    logic [bmr_pkg::BYTE_W-1:0]    rd;
    c  = int'(op.col) & (GRID_WIDTH - 1);
    r  = int'(op.row) & (GRID_HEIGHT - 1);
    rd = '0;
    case (op.func)
      bmr_pkg::FUNC_WRITE: grid_mem[c + r * GRID_WIDTH] = op.wval;
      bmr_pkg::FUNC_READ:  rd = grid_mem[c + r * GRID_WIDTH];
      bmr_pkg::FUNC_ROT_ROW: begin
        t = int'(op.amt) & (GRID_WIDTH - 1);
        for (int i = 0; i < GRID_WIDTH; i++) line[i] = grid_mem[i + r * GRID_WIDTH];
        for (int i = 0; i < GRID_WIDTH; i++) begin
          src = op.toward ? (i + GRID_WIDTH - t) % GRID_WIDTH : (i + t) % GRID_WIDTH;
          grid_mem[i + r * GRID_WIDTH] = line[src];
        end
      end
      default: begin
        t = int'(op.amt) & (GRID_HEIGHT - 1);
        for (int i = 0; i < GRID_HEIGHT; i++) line[i] = grid_mem[c + i * GRID_WIDTH];
        for (int i = 0; i < GRID_HEIGHT; i++) begin
          src = op.toward ? (i + GRID_HEIGHT - t) % GRID_HEIGHT : (i + t) % GRID_HEIGHT;
          grid_mem[c + i * GRID_WIDTH] = line[src];
        end
      end
    endcase
    return rd;
  endfunction

  function automatic void push_op(bmr_pkg::func_t f, int col, int row, int amt, int dir,
                                  int val, int drain);
    grid_op_t op;
    op.func       = f;
    op.col        = col[bmr_pkg::POS_W-1:0];
    op.row        = row[bmr_pkg::POS_W-1:0];
    op.amt        = amt[bmr_pkg::AMT_W-1:0];
    op.toward     = dir[0];
    op.wval       = val[bmr_pkg::BYTE_W-1:0];
    op.wait_drain = drain[0];
    pending_ops.push_back(op);
  endfunction

  // Driver: one transaction presented at a time, with a random gap after each.
  always @(posedge clk) begin
    bit nxt_valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      nxt_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        expected_bytes.push_back(apply_op(cur_op));
        sent_cnt++;
        nxt_valid = 1'b0;
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 4);
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].wait_drain && sent_cnt != checked_cnt)) begin
          cur_op = pending_ops.pop_front();
          in_ch.func        <= cur_op.func;
          in_ch.pos_col     <= cur_op.col;
          in_ch.pos_row     <= cur_op.row;
          in_ch.amount      <= cur_op.amt;
          in_ch.toward      <= cur_op.toward;
          in_ch.write_value <= cur_op.wval;
          nxt_valid = 1'b1;
        end
      end
      in_ch.valid <= nxt_valid;
    end
  end

  // Monitor: checks each result transaction and stalls ready at random.
  always @(posedge clk) begin
    logic [bmr_pkg::BYTE_W-1:0] want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        checked_cnt <= checked_cnt + 1;
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t ERROR read_value: expected none, actual %02h", $time,
                   out_ch.read_value);
        end else begin
          want = expected_bytes.pop_front();
          if (want !== out_ch.read_value) begin
            errors++;
            $display("%0t ERROR read_value: expected %02h, actual %02h", $time, want,
                     out_ch.read_value);
          end
        end
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 4);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ERROR: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int             r;
    bmr_pkg::func_t f;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.func        = bmr_pkg::FUNC_WRITE;
    in_ch.pos_col     = '0;
    in_ch.pos_row     = '0;
    in_ch.amount      = '0;
    in_ch.toward      = 1'b0;
    in_ch.write_value = '0;
    out_ch.ready      = 1'b0;
    sent_cnt          = 0;
    checked_cnt       = 0;
    errors            = 0;
    tx_burst          = 1'b0;
    rx_burst          = 1'b0;
    for (int i = 0; i < GRID_CELLS; i++) grid_mem[i] = '0;

    // Directed part: reset contents, extreme bytes, each rotation direction, and
    // zero amounts that must leave the row or column alone.
    push_op(bmr_pkg::FUNC_READ, 0, 0, 0, 0, 8'hFF, 0);
    push_op(bmr_pkg::FUNC_READ, 3, 3, 3, 1, 8'h00, 0);
    push_op(bmr_pkg::FUNC_WRITE, 3, 3, 0, 0, 8'hFF, 0);
    push_op(bmr_pkg::FUNC_WRITE, 0, 1, 3, 1, 8'hA5, 0);
    push_op(bmr_pkg::FUNC_WRITE, 1, 1, 0, 0, 8'h5A, 0);
    push_op(bmr_pkg::FUNC_WRITE, 2, 1, 0, 0, 8'h80, 0);
    push_op(bmr_pkg::FUNC_WRITE, 3, 1, 0, 0, 8'h01, 0);
    push_op(bmr_pkg::FUNC_WRITE, 2, 0, 0, 0, 8'h7E, 0);
    push_op(bmr_pkg::FUNC_WRITE, 2, 3, 0, 0, 8'h00, 0);
    push_op(bmr_pkg::FUNC_ROT_ROW, 3, 1, 1, 0, 8'hFF, 0);
    push_op(bmr_pkg::FUNC_READ, 0, 1, 0, 0, 8'h00, 0);
    push_op(bmr_pkg::FUNC_ROT_ROW, 0, 1, 3, 1, 8'h00, 0);
    push_op(bmr_pkg::FUNC_ROT_ROW, 2, 1, 0, 1, 8'h33, 0);
    push_op(bmr_pkg::FUNC_READ, 3, 1, 0, 0, 8'h00, 0);
    push_op(bmr_pkg::FUNC_ROT_COL, 2, 3, 2, 1, 8'hFF, 0);
    push_op(bmr_pkg::FUNC_READ, 2, 2, 0, 0, 8'h00, 0);
    push_op(bmr_pkg::FUNC_ROT_COL, 2, 0, 1, 0, 8'h00, 0);
    push_op(bmr_pkg::FUNC_ROT_COL, 3, 2, 0, 0, 8'hC3, 0);
    push_op(bmr_pkg::FUNC_READ, 2, 0, 0, 0, 8'h00, 0);
    push_op(bmr_pkg::FUNC_READ, 2, 1, 0, 0, 8'h00, 0);
    push_op(bmr_pkg::FUNC_READ, 2, 3, 0, 0, 8'h00, 0);
    push_op(bmr_pkg::FUNC_READ, 3, 3, 0, 0, 8'h00, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 9);
      if (r < 3) f = bmr_pkg::FUNC_WRITE;
      else if (r < 6) f = bmr_pkg::FUNC_READ;
      else if (r < 8) f = bmr_pkg::FUNC_ROT_ROW;
      else f = bmr_pkg::FUNC_ROT_COL;
      push_op(f, $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
              $urandom_range(0, 1), $urandom_range(0, 255), int'((n % 200) == 0));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_ch.valid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bmr_pkg.sv
design/bmr_chan_if.sv
design/bmr_ctrl.sv
design/bmr_datapath.sv
design/byte_matrix_row_col_rotator_core.sv
verif/byte_matrix_row_col_rotator_core_tb.sv
